>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file imports this package.
package spq_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned OccW       = 7;
  localparam int unsigned SpqDepth   = 64;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } spq_status_e;

  typedef enum logic {
    ModeEnq = 1'b0,
    ModeDeq = 1'b1
  } spq_mode_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic [DataW-1:0] prio;
  } spq_entry_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

>>> hdl/spq_in_if.sv
// Input channel of the sorted priority queue: one operation per beat.
// Depends on spq_pkg.
interface spq_in_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [DataW-1:0] in_data;
  logic [DataW-1:0] in_priority;

  modport source (output valid, mode, in_data, in_priority, input ready);
  modport sink   (input valid, mode, in_data, in_priority, output ready);
endinterface

>>> hdl/spq_out_if.sv
// Result channel of the sorted priority queue: one result per beat.
// Depends on spq_pkg.
interface spq_out_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  out_data;
  logic [1:0]        status;
  logic [OccW-1:0]   occupancy;

  modport source (output valid, out_data, status, occupancy, input ready);
  modport sink   (input valid, out_data, status, occupancy, output ready);
endinterface

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts right on insert
// and left on removal. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  spq_cmd_t         cmd_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  spq_entry_t       left_i,
  input  logic             left_gt_i,
  input  spq_entry_t       right_i,
  output logic             gt_o,
  output spq_entry_t       q_o
);

  spq_entry_t entry_q, entry_d;

  // Empty slots count as larger than anything, so the chain stays monotonic.
  assign gt_o = (cnt_i <= CNT_W'(IDX)) ||
                ($signed(entry_q.prio) > $signed(cmd_i.entry.prio));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq && gt_o) begin
      entry_d = left_gt_i ? left_i : cmd_i.entry;
    end else if (cmd_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

>>> hdl/sorted_priority_queue.sv
// Sorted priority queue of up to DEPTH entries, each a 32-bit data word with
// a signed 32-bit priority; the smallest priority leaves first and equal
// priorities leave in arrival order. Every operation (enqueue or dequeue)
// gives one result beat with status and occupancy, so one operation is
// accepted per cycle while the result side keeps up; the whole chain of
// cells updates at once on each operation, each cell comparing its own
// priority with the new one in parallel. A stalled result holds the input
// off through ready. Enqueue into a full queue reports full; dequeue from an
// empty queue returns -1 and reports empty. Depends on spq_pkg, spq_in_if,
// spq_out_if and spq_cell.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = SpqDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept, full, empty;
  spq_cmd_t        cmd;

  logic              out_valid_q;
  logic [DataW-1:0]  out_data_q, out_data_d;
  spq_status_e       status_q, status_d;
  logic [OccW-1:0]   occ_q;
  logic [CntW+OccW-1:0] occ_ext;

  spq_entry_t cell_q  [DEPTH];
  logic       cell_gt [DEPTH];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (cnt_q == CntW'(DEPTH));
  assign empty      = (cnt_q == '0);

  assign cmd.enq        = accept && (in_i.mode == ModeEnq) && !full;
  assign cmd.deq        = accept && (in_i.mode == ModeDeq) && !empty;
  assign cmd.entry.data = in_i.in_data;
  assign cmd.entry.prio = in_i.in_priority;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left, right;
    logic       left_gt;
    if (i == 0) begin : g_head
      assign left    = cmd.entry;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left    = cell_q[i-1];
      assign left_gt = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cell_q[i+1];
    end
    spq_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .cnt_i     (cnt_q),
      .left_i    (left),
      .left_gt_i (left_gt),
      .right_i   (right),
      .gt_o      (cell_gt[i]),
      .q_o       (cell_q[i])
    );
  end

  always_comb begin
    cnt_d      = cnt_q;
    out_data_d = '0;
    status_d   = StDone;
    if (in_i.mode == ModeEnq) begin
      if (full) begin
        status_d = StFull;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        out_data_d = '1;
        status_d   = StEmpty;
      end else begin
        out_data_d = cell_q[0].data;
        cnt_d      = cnt_q - CntW'(1);
      end
    end
  end

  // occupancy is the count modulo 128
  assign occ_ext = {{OccW{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      status_q   <= status_d;
      occ_q      <= occ_ext[OccW-1:0];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_data  = out_data_q;
  assign out_o.status    = status_q;
  assign out_o.occupancy = occ_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.mode == ModeEnq && full) |=> (status_q == StFull && $stable(cnt_q)))
    else $error("enqueue into full queue not rejected");

  a_deq_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.mode == ModeDeq && !empty) |=>
      (out_data_q == $past(cell_q[0].data) && status_q == StDone))
    else $error("dequeue did not return head entry");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= CntW'(2)) |-> ($signed(cell_q[0].prio) <= $signed(cell_q[1].prio)))
    else $error("head entries out of order");

endmodule
